// ===== sv/sct_pkg.sv =====
// Shared types and constants for the segment crossing test block.
// No dependencies; used by sct_orient and segment_crossing_test_top.
package sct_pkg;

   // Width of every coordinate field on the request side.
   localparam int FIELD_BITS = 16;
   // Width of the margin scale register.
   localparam int CSR_BITS = 16;
   // Fixed-point position of the margin scale (units of 2^-20).
   localparam int MARGIN_FRAC_BITS = 20;
   // Margin scale after reset, about 0.0001 of the summed extents.
   localparam logic [CSR_BITS-1:0] MARGIN_RESET = 16'd105;

   // Which test decided the outcome.
   typedef enum logic [1:0] {
      VERDICT_BOX_REJECT = 2'd0,
      VERDICT_B_SAME_SIDE = 2'd1,
      VERDICT_A_SAME_SIDE = 2'd2,
      VERDICT_CROSSING = 2'd3
   } verdict_type;

   // Sign of a doubled triangle area; both low means zero.
   typedef struct packed {
      logic pos;
      logic neg;
   } orient_sign_type;

endpackage

// ===== sv/sct_orient.sv =====
// Three-stage orientation unit: sign of the doubled signed area of (p1, p2, p3).
// Depends on sct_pkg for the sign struct.
module sct_orient #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic signed [COORD_BITS-1:0]   p1_x,
   input  logic signed [COORD_BITS-1:0]   p1_y,
   input  logic signed [COORD_BITS-1:0]   p2_x,
   input  logic signed [COORD_BITS-1:0]   p2_y,
   input  logic signed [COORD_BITS-1:0]   p3_x,
   input  logic signed [COORD_BITS-1:0]   p3_y,
   output sct_pkg::orient_sign_type       sign_out
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] d21_x_ff, d21_y_ff, d31_x_ff, d31_y_ff;
   logic signed [PW-1:0] prod_l_ff, prod_r_ff;
   sct_pkg::orient_sign_type sign_ff;

   // stage 1: edge vectors
   always_ff @(posedge clock) begin
      d21_x_ff <= DW'(p2_x) - DW'(p1_x);
      d21_y_ff <= DW'(p2_y) - DW'(p1_y);
      d31_x_ff <= DW'(p3_x) - DW'(p1_x);
      d31_y_ff <= DW'(p3_y) - DW'(p1_y);
   end

   // stage 2: cross product terms
   always_ff @(posedge clock) begin
      prod_l_ff <= PW'(d21_x_ff) * PW'(d31_y_ff);
      prod_r_ff <= PW'(d31_x_ff) * PW'(d21_y_ff);
   end

   // stage 3: sign of the difference, by comparing the terms
   always_ff @(posedge clock) begin
      sign_ff.pos <= prod_l_ff > prod_r_ff;
      sign_ff.neg <= prod_l_ff < prod_r_ff;
   end

   assign sign_out = sign_ff;

endmodule

// ===== sv/segment_crossing_test_top.sv =====
// Segment crossing test: top level with box reject and four orientation units.
// Depends on sct_pkg and sct_orient.
//
// Usage
//   Request: drive the eight endpoint coordinates on req_* and raise start.
//   A transfer takes place at each rising edge with start high and busy low.
//   busy is always low: the pipeline never stalls, so a new segment pair
//   may be offered on every cycle.
//   Response: rsp_valid is high for exactly one cycle with rsp_crosses and
//   rsp_verdict; the receiver cannot hold it off, and needs no way to, as
//   the block has no backpressure anywhere.
//   Pipeline: the result passes five register stages after the request
//   transfer (input, difference, product/extent sum, sign/margin, output).
//   Throughput is one pair per cycle; the rate is set by the pipeline,
//   with two multipliers side by side in each orientation unit.
//   Config: csr_we writes csr_wdata to the margin scale (units of 2^-20 of
//   the summed box extents). Write it only while no transfer is in flight.
//   Reset (synchronous, active high) empties the pipeline and sets the
//   margin scale to 105; items in flight are dropped.
//   Coordinates are the low COORD_BITS bits of each field, taken as signed; a wider COORD_BITS zero-extends the field.
module segment_crossing_test_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_a_start_x,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_a_start_y,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_a_end_x,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_a_end_y,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_b_start_x,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_b_start_y,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_b_end_x,
   input  logic [sct_pkg::FIELD_BITS-1:0]     req_b_end_y,
   output logic                               rsp_valid,
   output logic                               rsp_crosses,
   output logic [1:0]                         rsp_verdict,
   input  logic                               csr_we,
   input  logic [sct_pkg::CSR_BITS-1:0]       csr_wdata
);

   localparam int CW  = COORD_BITS;
   localparam int DW  = CW + 1;                 // coordinate difference
   localparam int XW  = CW + 2;                 // sum of four extents
   localparam int MW  = XW + sct_pkg::CSR_BITS; // scaled margin
   localparam int SW  = DW - 1 + sct_pkg::MARGIN_FRAC_BITS; // positive gap << 20
   localparam int EW  = (CW > sct_pkg::FIELD_BITS) ? CW : sct_pkg::FIELD_BITS;

   logic accept;

   // margin scale register
   logic [sct_pkg::CSR_BITS-1:0] margin_scale_ff;

   // valid bits through the stages
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, rsp_valid_ff;

   // stage 1: coordinates
   logic signed [CW-1:0] a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;
   logic signed [CW-1:0] b_sx_ff, b_sy_ff, b_ex_ff, b_ey_ff;

   // stage 2..4: box gaps travel alongside; extents then sum then margin
   logic signed [DW-1:0] gap_s2_ff [4];
   logic signed [DW-1:0] gap_s3_ff [4];
   logic signed [DW-1:0] gap_s4_ff [4];
   logic [CW-1:0] extent_ff [4];
   logic [XW-1:0] ext_sum_ff;
   logic [MW-1:0] marg_ff;

   // stage 2 combinational box terms
   logic signed [CW-1:0] min0x, max0x, min0y, max0y;
   logic signed [CW-1:0] min1x, max1x, min1y, max1y;
   logic signed [DW-1:0] gap_in [4];
   logic [CW-1:0] extent_in [4];

   // output stage
   logic [3:0] gap_over;
   sct_pkg::orient_sign_type o1, o2, o3, o4;
   sct_pkg::verdict_type verdict_in, verdict_ff;

   assign busy = 1'b0;
   assign accept = start && !busy;

   // low COORD_BITS of a field, sign-extended; wider widths see the field as unsigned
   function automatic logic signed [CW-1:0] to_coord(input logic [sct_pkg::FIELD_BITS-1:0] f);
      logic [EW-1:0] ext;
      ext = EW'(f);
      return ext[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_scale_ff <= sct_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         margin_scale_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid1_ff    <= accept;
         valid2_ff    <= valid1_ff;
         valid3_ff    <= valid2_ff;
         valid4_ff    <= valid3_ff;
         rsp_valid_ff <= valid4_ff;
      end
   end

   // stage 1: capture the request
   always_ff @(posedge clock) begin
      if (accept) begin
         a_sx_ff <= to_coord(req_a_start_x);
         a_sy_ff <= to_coord(req_a_start_y);
         a_ex_ff <= to_coord(req_a_end_x);
         a_ey_ff <= to_coord(req_a_end_y);
         b_sx_ff <= to_coord(req_b_start_x);
         b_sy_ff <= to_coord(req_b_start_y);
         b_ex_ff <= to_coord(req_b_end_x);
         b_ey_ff <= to_coord(req_b_end_y);
      end
   end

   // stage 2: bounding boxes, gaps and extents
   always_comb begin
      min0x = (a_sx_ff < a_ex_ff) ? a_sx_ff : a_ex_ff;
      max0x = (a_sx_ff < a_ex_ff) ? a_ex_ff : a_sx_ff;
      min0y = (a_sy_ff < a_ey_ff) ? a_sy_ff : a_ey_ff;
      max0y = (a_sy_ff < a_ey_ff) ? a_ey_ff : a_sy_ff;
      min1x = (b_sx_ff < b_ex_ff) ? b_sx_ff : b_ex_ff;
      max1x = (b_sx_ff < b_ex_ff) ? b_ex_ff : b_sx_ff;
      min1y = (b_sy_ff < b_ey_ff) ? b_sy_ff : b_ey_ff;
      max1y = (b_sy_ff < b_ey_ff) ? b_ey_ff : b_sy_ff;
      // axis test order: B left of A, A left of B, B below A, A below B
      gap_in[0] = DW'(min0x) - DW'(max1x);
      gap_in[1] = DW'(min1x) - DW'(max0x);
      gap_in[2] = DW'(min0y) - DW'(max1y);
      gap_in[3] = DW'(min1y) - DW'(max0y);
      extent_in[0] = CW'(DW'(max0x) - DW'(min0x));
      extent_in[1] = CW'(DW'(max0y) - DW'(min0y));
      extent_in[2] = CW'(DW'(max1x) - DW'(min1x));
      extent_in[3] = CW'(DW'(max1y) - DW'(min1y));
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         gap_s2_ff[k] <= gap_in[k];
         gap_s3_ff[k] <= gap_s2_ff[k];
         gap_s4_ff[k] <= gap_s3_ff[k];
         extent_ff[k] <= extent_in[k];
      end
   end

   // stage 3: extent sum; stage 4: scaled margin
   always_ff @(posedge clock) begin
      ext_sum_ff <= XW'(extent_ff[0]) + XW'(extent_ff[1])
                  + XW'(extent_ff[2]) + XW'(extent_ff[3]);
      marg_ff    <= MW'(ext_sum_ff) * MW'(margin_scale_ff);
   end

   // orientation units, three stages each, aligned with stage 4
   sct_orient #(.COORD_BITS(CW)) u_orient_b_start (
      .clock(clock),
      .p1_x(a_sx_ff), .p1_y(a_sy_ff), .p2_x(a_ex_ff), .p2_y(a_ey_ff),
      .p3_x(b_sx_ff), .p3_y(b_sy_ff), .sign_out(o1)
   );
   sct_orient #(.COORD_BITS(CW)) u_orient_b_end (
      .clock(clock),
      .p1_x(a_sx_ff), .p1_y(a_sy_ff), .p2_x(a_ex_ff), .p2_y(a_ey_ff),
      .p3_x(b_ex_ff), .p3_y(b_ey_ff), .sign_out(o2)
   );
   sct_orient #(.COORD_BITS(CW)) u_orient_a_start (
      .clock(clock),
      .p1_x(b_sx_ff), .p1_y(b_sy_ff), .p2_x(b_ex_ff), .p2_y(b_ey_ff),
      .p3_x(a_sx_ff), .p3_y(a_sy_ff), .sign_out(o3)
   );
   sct_orient #(.COORD_BITS(CW)) u_orient_a_end (
      .clock(clock),
      .p1_x(b_sx_ff), .p1_y(b_sy_ff), .p2_x(b_ex_ff), .p2_y(b_ey_ff),
      .p3_x(a_ex_ff), .p3_y(a_ey_ff), .sign_out(o4)
   );

   // output stage: gap beyond margin (only a positive gap can exceed it),
   // then same-side tests in order
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         gap_over[k] = !gap_s4_ff[k][DW-1] &&
                       ({gap_s4_ff[k][DW-2:0], {sct_pkg::MARGIN_FRAC_BITS{1'b0}}}
                        > SW'(marg_ff));
      end
      if (|gap_over) begin
         verdict_in = sct_pkg::VERDICT_BOX_REJECT;
      end else if ((o1.pos && o2.pos) || (o1.neg && o2.neg)) begin
         verdict_in = sct_pkg::VERDICT_B_SAME_SIDE;
      end else if ((o3.pos && o4.pos) || (o3.neg && o4.neg)) begin
         verdict_in = sct_pkg::VERDICT_A_SAME_SIDE;
      end else begin
         verdict_in = sct_pkg::VERDICT_CROSSING;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_crosses = (verdict_ff == sct_pkg::VERDICT_CROSSING);

endmodule
